### rtl/fals_pkg.sv
// shared types and constants for the first-at-least search table
package fals_pkg;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;

    // input item operation codes
    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    // work a cell does on the token it holds
    typedef enum logic [1:0]
    {
        CELL_WRITE,
        CELL_PROBE,
        CELL_CLIMB,
        CELL_DESCEND
    } cell_op_t;

    // control of a token moving up the chain
    typedef struct packed
    {
        logic     valid;
        cell_op_t op;
    } tok_ctl_t;

    // end of an item, raised by the cell where its walk stops
    typedef struct packed
    {
        logic valid;
        logic result;
        logic found;
    } fin_t;

    // top level sequencer states
    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } state_t;

endpackage

### rtl/fals_ram.sv
// generic simple dual port ram with registered read
module fals_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/fals_cell.sv
// one tree level: node maxima of that level and the walk step done there
module fals_cell #(
    parameter int LEAF_W = 10,
    parameter int LEVEL  = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 clear,
    input  logic [LEAF_W-1:0]                    clear_addr,
    input  fals_pkg::tok_ctl_t                   up_in_ctl,
    input  logic [LEAF_W-1:0]                    up_in_node,
    input  logic signed [fals_pkg::VALUE_W-1:0]  up_in_value,
    input  logic                                 dn_in_valid,
    input  logic [LEAF_W-1:0]                    dn_in_node,
    input  logic signed [fals_pkg::VALUE_W-1:0]  dn_in_value,
    output fals_pkg::tok_ctl_t                   up_out_ctl,
    output logic [LEAF_W-1:0]                    up_out_node,
    output logic signed [fals_pkg::VALUE_W-1:0]  up_out_value,
    output logic                                 dn_out_valid,
    output logic [LEAF_W-1:0]                    dn_out_node,
    output logic signed [fals_pkg::VALUE_W-1:0]  dn_out_value,
    output fals_pkg::fin_t                       fin,
    output logic [LEAF_W-1:0]                    fin_pos
);

    localparam int LVL_W   = LEAF_W - LEVEL;
    localparam bit IS_TOP  = (LEVEL == LEAF_W - 1);
    localparam bit IS_LEAF = (LEVEL == 0);

    logic                                pend_reg;
    fals_pkg::cell_op_t                  op_reg;
    logic [LVL_W-1:0]                    node_reg;
    logic signed [fals_pkg::VALUE_W-1:0] value_reg;

    logic                                arr_valid;
    fals_pkg::cell_op_t                  arr_op;
    logic [LVL_W-1:0]                    arr_node;
    logic signed [fals_pkg::VALUE_W-1:0] arr_value;
    logic                                loop;

    logic [LVL_W-1:0]                    rd_addr;
    logic [fals_pkg::VALUE_W-1:0]        rd_data;
    logic                                ram_we;
    logic [LVL_W-1:0]                    ram_waddr;
    logic [fals_pkg::VALUE_W-1:0]        ram_wdata;

    logic                                ge;
    logic [LVL_W-1:0]                    sib;
    logic [LVL_W-1:0]                    child;
    logic [LEAF_W-1:0]                   parent;

    // token arriving this cycle: from above, from below, or a missed probe retried
    always_comb
    begin
        arr_valid = 1'b0;
        arr_op    = fals_pkg::CELL_WRITE;
        arr_node  = node_reg;
        arr_value = value_reg;
        if (dn_in_valid)
        begin
            arr_valid = 1'b1;
            arr_op    = fals_pkg::CELL_DESCEND;
            arr_node  = LVL_W'(dn_in_node << 1);
            arr_value = dn_in_value;
        end
        else if (up_in_ctl.valid)
        begin
            arr_valid = 1'b1;
            arr_op    = up_in_ctl.op;
            arr_node  = LVL_W'(up_in_node);
            arr_value = up_in_value;
        end
        else if (loop)
        begin
            arr_valid = 1'b1;
            arr_op    = fals_pkg::CELL_CLIMB;
        end
    end

    // node read for each kind of step
    always_comb
    begin
        case (arr_op)
            fals_pkg::CELL_WRITE:   rd_addr = arr_node ^ LVL_W'(1);
            fals_pkg::CELL_CLIMB:   rd_addr = arr_node | LVL_W'(1);
            fals_pkg::CELL_PROBE:   rd_addr = arr_node;
            fals_pkg::CELL_DESCEND: rd_addr = arr_node;
            default:                rd_addr = arr_node;
        endcase
    end

    // clearing pass or a write token writes the level memory
    assign ram_we    = clear || (arr_valid && (arr_op == fals_pkg::CELL_WRITE));
    assign ram_waddr = clear ? LVL_W'(clear_addr) : arr_node;
    assign ram_wdata = clear ? '0 : arr_value;

    fals_ram #(
        .WIDTH (fals_pkg::VALUE_W),
        .DEPTH (2 ** LVL_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // token held while its node read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= arr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (arr_valid)
        begin
            op_reg    <= arr_op;
            node_reg  <= arr_node;
            value_reg <= arr_value;
        end
    end

    assign ge     = $signed(rd_data) >= value_reg;
    assign sib    = node_reg | LVL_W'(1);
    assign child  = ge ? node_reg : sib;
    assign parent = LEAF_W'(node_reg >> 1);

    // step decision, handed to a neighbor or ending the item
    always_comb
    begin
        up_out_ctl   = '{valid: 1'b0, op: fals_pkg::CELL_WRITE};
        up_out_node  = parent;
        up_out_value = value_reg;
        dn_out_valid = 1'b0;
        dn_out_node  = LEAF_W'(sib);
        dn_out_value = value_reg;
        fin          = '{valid: 1'b0, result: 1'b0, found: 1'b0};
        fin_pos      = LEAF_W'(node_reg);
        loop         = 1'b0;
        if (pend_reg)
        begin
            case (op_reg)
                fals_pkg::CELL_WRITE:
                begin
                    // refresh the parent with the larger of this node and its sibling
                    if (IS_TOP)
                    begin
                        fin.valid = 1'b1;
                    end
                    else
                    begin
                        up_out_ctl   = '{valid: 1'b1, op: fals_pkg::CELL_WRITE};
                        up_out_value = ge ? $signed(rd_data) : value_reg;
                    end
                end
                fals_pkg::CELL_PROBE:
                begin
                    // start leaf itself
                    if (ge)
                    begin
                        fin = '{valid: 1'b1, result: 1'b1, found: 1'b1};
                    end
                    else
                    begin
                        loop = 1'b1;
                    end
                end
                fals_pkg::CELL_CLIMB:
                begin
                    // left child whose right sibling qualifies turns the walk down
                    if (!node_reg[0] && ge)
                    begin
                        if (IS_LEAF)
                        begin
                            fin     = '{valid: 1'b1, result: 1'b1, found: 1'b1};
                            fin_pos = LEAF_W'(sib);
                        end
                        else
                        begin
                            dn_out_valid = 1'b1;
                        end
                    end
                    else if (IS_TOP)
                    begin
                        fin = '{valid: 1'b1, result: 1'b1, found: 1'b0};
                    end
                    else
                    begin
                        up_out_ctl = '{valid: 1'b1, op: fals_pkg::CELL_CLIMB};
                    end
                end
                fals_pkg::CELL_DESCEND:
                begin
                    // leftmost qualifying child
                    if (IS_LEAF)
                    begin
                        fin     = '{valid: 1'b1, result: 1'b1, found: 1'b1};
                        fin_pos = LEAF_W'(child);
                    end
                    else
                    begin
                        dn_out_valid = 1'b1;
                        dn_out_node  = LEAF_W'(child);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

### rtl/first_at_least_search_table_unit.sv
// top level of the first-at-least search table
// Table of TABLE_DEPTH signed 32-bit entries, all zero after reset, with a tree
// of range maxima held as a chain of cells, one cell and one ram per tree level
// (log2 of the leaf count rounded up, 10 for 1024 entries). After reset a
// clearing pass over the leaf addresses zeroes every level while no beat is
// taken. One item is handled at a time, and each tree level's step waits on
// the registered read of that level's ram. An in-range item holds the chain
// from its accepting cycle through the cycle its walk ends; the next beat is
// taken once the sequencer is idle again and the skid stage is empty. A write
// climbs from its leaf to the top; a search probes its start leaf, then climbs
// and descends as needed; an out-of-range item starts no walk. Writes give no
// result beat; each search gives one, registered when its walk ends or, out of
// range, when it is taken. A finished result waits in an output register with
// a one-beat skid behind it, so the next item is taken while it is unread.
module first_at_least_search_table_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [fals_pkg::INDEX_W-1:0]        index,
    input  logic signed [fals_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                found,
    output logic [fals_pkg::INDEX_W-1:0]        position
);

    localparam int LEAF_W = $clog2(TABLE_DEPTH);
    localparam int CMP_W  = (LEAF_W + 1 > fals_pkg::INDEX_W) ? LEAF_W + 1 : fals_pkg::INDEX_W;

    fals_pkg::state_t                    state_reg;
    fals_pkg::state_t                    state_next;
    logic [LEAF_W-1:0]                   clr_cnt_reg;
    logic                                clearing;

    fals_pkg::tok_ctl_t                  up_ctl   [LEAF_W+1];
    logic [LEAF_W-1:0]                   up_node  [LEAF_W+1];
    logic signed [fals_pkg::VALUE_W-1:0] up_value [LEAF_W+1];
    logic                                dn_valid [LEAF_W+1];
    logic [LEAF_W-1:0]                   dn_node  [LEAF_W+1];
    logic signed [fals_pkg::VALUE_W-1:0] dn_value [LEAF_W+1];
    fals_pkg::fin_t                      fin_c    [LEAF_W];
    logic [LEAF_W-1:0]                   fin_pos_c [LEAF_W];

    fals_pkg::fin_t                      fin_all;
    logic [LEAF_W-1:0]                   fin_pos_all;

    logic                                in_take;
    logic                                in_range;
    logic                                is_search;
    logic                                res_valid;
    logic                                res_found;
    logic [fals_pkg::INDEX_W-1:0]        res_pos;
    logic                                out_take;

    logic                                out_valid_reg;
    logic                                found_reg;
    logic [fals_pkg::INDEX_W-1:0]        position_reg;
    logic                                hold_valid_reg;
    logic                                hold_found_reg;
    logic [fals_pkg::INDEX_W-1:0]        hold_pos_reg;

    // input beat decode
    assign in_take   = in_valid && in_ready;
    assign in_range  = CMP_W'(index) < CMP_W'(TABLE_DEPTH);
    assign is_search = (operation == fals_pkg::OP_SEARCH);

    // token injected into the leaf cell
    assign up_ctl[0]   = '{valid: in_take && in_range,
                           op: is_search ? fals_pkg::CELL_PROBE : fals_pkg::CELL_WRITE};
    assign up_node[0]  = LEAF_W'(index);
    assign up_value[0] = value;

    // nothing comes down into the top cell
    assign dn_valid[LEAF_W] = 1'b0;
    assign dn_node[LEAF_W]  = '0;
    assign dn_value[LEAF_W] = '0;

    // chain of level cells, leaves first
    for (genvar k = 0; k < LEAF_W; k++)
    begin : g_cell
        fals_cell #(
            .LEAF_W (LEAF_W),
            .LEVEL  (k)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .clear        (clearing),
            .clear_addr   (clr_cnt_reg),
            .up_in_ctl    (up_ctl[k]),
            .up_in_node   (up_node[k]),
            .up_in_value  (up_value[k]),
            .dn_in_valid  (dn_valid[k+1]),
            .dn_in_node   (dn_node[k+1]),
            .dn_in_value  (dn_value[k+1]),
            .up_out_ctl   (up_ctl[k+1]),
            .up_out_node  (up_node[k+1]),
            .up_out_value (up_value[k+1]),
            .dn_out_valid (dn_valid[k]),
            .dn_out_node  (dn_node[k]),
            .dn_out_value (dn_value[k]),
            .fin          (fin_c[k]),
            .fin_pos      (fin_pos_c[k])
        );
    end

    // gather the end of an item from whichever cell raised it
    always_comb
    begin
        fin_all     = '{valid: 1'b0, result: 1'b0, found: 1'b0};
        fin_pos_all = '0;
        for (int k = 0; k < LEAF_W; k++)
        begin
            fin_all.valid  = fin_all.valid  | fin_c[k].valid;
            fin_all.result = fin_all.result | (fin_c[k].valid & fin_c[k].result);
            fin_all.found  = fin_all.found  | (fin_c[k].valid & fin_c[k].found);
            fin_pos_all    = fin_pos_all    | (fin_c[k].valid ? fin_pos_c[k] : '0);
        end
    end

    // result beat: out-of-range search at once, otherwise at the end of the walk
    assign res_valid = (in_take && is_search && !in_range) || (fin_all.valid && fin_all.result);
    assign res_found = fin_all.valid && fin_all.found
                       && (CMP_W'(fin_pos_all) < CMP_W'(TABLE_DEPTH));
    assign res_pos   = res_found ? fals_pkg::INDEX_W'(fin_pos_all) : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fals_pkg::ST_CLEAR:
            begin
                if (&clr_cnt_reg)
                begin
                    state_next = fals_pkg::ST_IDLE;
                end
            end
            fals_pkg::ST_IDLE:
            begin
                if (in_take && in_range)
                begin
                    state_next = fals_pkg::ST_BUSY;
                end
            end
            fals_pkg::ST_BUSY:
            begin
                if (fin_all.valid)
                begin
                    state_next = fals_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fals_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        clearing = 1'b0;
        in_ready = 1'b0;
        case (state_reg)
            fals_pkg::ST_CLEAR: clearing = 1'b1;
            fals_pkg::ST_IDLE:  in_ready = !hold_valid_reg;
            fals_pkg::ST_BUSY:  in_ready = 1'b0;
            default:            clearing = 1'b0;
        endcase
    end

    // sequencer and clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fals_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + LEAF_W'(1);
            end
        end
    end

    // output register with skid behind it
    assign out_take = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    hold_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg  <= hold_valid_reg;
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                found_reg    <= res_found;
                position_reg <= res_pos;
            end
            else
            begin
                hold_found_reg <= res_found;
                hold_pos_reg   <= res_pos;
            end
        end
        else if (out_take && hold_valid_reg)
        begin
            found_reg    <= hold_found_reg;
            position_reg <= hold_pos_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

    // tokens never leave the ends of the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        !(up_ctl[LEAF_W].valid || dn_valid[0]))
    else $error("token left the end of the cell chain");

    // a walk only ends while an item is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        fin_all.valid |-> (state_reg == fals_pkg::ST_BUSY))
    else $error("walk ended with no item in flight");

    // a new result never meets a full skid stage
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !hold_valid_reg)
    else $error("result beat would overwrite the skid stage");

endmodule
